// File: src/rgb_led_effect_controller_defines.svh
// Assertion macros used by the checker file.
`ifndef RGB_LED_EFFECT_CONTROLLER_DEFINES_SVH
`define RGB_LED_EFFECT_CONTROLLER_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RLEC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define RLEC_ASSERT(label, prop, msg) \
  `RLEC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: src/rlec_pkg.sv
`timescale 1ns / 1ps

package rlec_pkg;

  localparam int BLINK_INTERVAL = 250;
  localparam int PULSE_PERIOD   = 1000;
  localparam int PULSE_HALF     = (PULSE_PERIOD / 2 == 0) ? 1 : PULSE_PERIOD / 2;

  // Reciprocal of the half period for the triangle scale, one correction step after.
  localparam int RECIP_SHIFT = 28;
  localparam logic [28:0] PULSE_RECIP = 29'((64'd1 << RECIP_SHIFT) / PULSE_HALF);

  localparam logic [7:0] DUTY_MAX        = 8'd255;
  localparam logic [7:0] FULL_DUTY_RESET = 8'd255;
  localparam logic [1:0] LAST_CH         = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PLAY   = 2'd1,
    OP_EFFECT = 2'd2,
    OP_NONE   = 2'd3
  } rlec_op_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_SOLID = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_PULSE = 2'd3
  } rlec_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCALE_MUL,
    ST_SCALE_FIX,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_FINISH
  } rlec_state_e;

  typedef struct packed {
    logic       capture;
    logic       exec;
    logic       scale_mul;
    logic       scale_fix;
    logic       mul1;
    logic       div1;
    logic       mul2;
    logic       div2;
    logic [1:0] ch;
    logic       load_out;
  } rlec_cmd_t;

  typedef struct packed {
    logic draw;
  } rlec_status_t;

  // Exact x / 255 for any x up to 255 * 255: 32897 / 2^23 sits just above 1/255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * 33'd32897;
    return p[30:23];
  endfunction

endpackage

// File: src/rgb_led_effect_controller.sv
// Sequence: each input beat is captured and run in EXEC; a status change, a held display
//   or a rejected command then goes to FINISH, while a drawn effect first passes the
//   scale steps and three channels through one shared multiply and divide-by-255 stage.
// Throughput: one item at a time; the next beat is taken once the result is in the
//   output register, which waits in FINISH while the previous result is not yet taken.
// Reset (rst_ni, async, active low): full duty 255, status display stopped, no effect.
`timescale 1ns / 1ps

module rgb_led_effect_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] play, [8:1] effect_mode, [16:9] red_level, [24:17] green_level,
  // [32:25] blue_level, [48:33] duration, [55:49] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] red_duty, [15:8] green_duty, [23:16] blue_duty, [24] accepted,
  // [25] effect_running, [31:26] zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  rlec_pkg::rlec_cmd_t    cmd;
  rlec_pkg::rlec_status_t status;

  rlec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rlec_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: src/rlec_ctrl.sv
`timescale 1ns / 1ps

module rlec_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  rlec_pkg::rlec_status_t status_i,
  output rlec_pkg::rlec_cmd_t    cmd_o
);

  rlec_pkg::rlec_state_e state_q, state_d;
  logic [1:0] ch_q, ch_d;
  logic       out_valid_q, out_valid_d;
  logic       load_out;

  assign load_out = (state_q == rlec_pkg::ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      rlec_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rlec_pkg::ST_EXEC;
      end
      rlec_pkg::ST_EXEC: begin
        state_d = status_i.draw ? rlec_pkg::ST_SCALE_MUL : rlec_pkg::ST_FINISH;
      end
      rlec_pkg::ST_SCALE_MUL: state_d = rlec_pkg::ST_SCALE_FIX;
      rlec_pkg::ST_SCALE_FIX: state_d = rlec_pkg::ST_MUL1;
      rlec_pkg::ST_MUL1:      state_d = rlec_pkg::ST_DIV1;
      rlec_pkg::ST_DIV1:      state_d = rlec_pkg::ST_MUL2;
      rlec_pkg::ST_MUL2:      state_d = rlec_pkg::ST_DIV2;
      rlec_pkg::ST_DIV2: begin
        if (ch_q == rlec_pkg::LAST_CH) begin
          ch_d    = 2'd0;
          state_d = rlec_pkg::ST_FINISH;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = rlec_pkg::ST_MUL1;
        end
      end
      rlec_pkg::ST_FINISH: begin
        if (load_out) state_d = rlec_pkg::ST_IDLE;
      end
      default: state_d = rlec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    in_ready_o        = (state_q == rlec_pkg::ST_IDLE);
    cmd_o.capture     = in_ready_o && in_valid_i;
    cmd_o.exec        = (state_q == rlec_pkg::ST_EXEC);
    cmd_o.scale_mul   = (state_q == rlec_pkg::ST_SCALE_MUL);
    cmd_o.scale_fix   = (state_q == rlec_pkg::ST_SCALE_FIX);
    cmd_o.mul1        = (state_q == rlec_pkg::ST_MUL1);
    cmd_o.div1        = (state_q == rlec_pkg::ST_DIV1);
    cmd_o.mul2        = (state_q == rlec_pkg::ST_MUL2);
    cmd_o.div2        = (state_q == rlec_pkg::ST_DIV2);
    cmd_o.ch          = ch_q;
    cmd_o.load_out    = load_out;
    out_valid_o       = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlec_pkg::ST_IDLE;
      ch_q        <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/rlec_datapath.sv
`timescale 1ns / 1ps

module rlec_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rlec_pkg::rlec_cmd_t    cmd_i,
  output rlec_pkg::rlec_status_t status_o,
  input  logic [55:0]           in_data_i,
  input  logic [1:0]            in_op_i,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  output logic [31:0]           out_data_o
);

  localparam logic [10:0] PERIOD_W  = 11'(rlec_pkg::PULSE_PERIOD);
  localparam logic [9:0]  PERIOD_10 = 10'(rlec_pkg::PULSE_PERIOD);
  localparam logic [9:0]  HALF_10   = 10'(rlec_pkg::PULSE_HALF);
  localparam logic [17:0] HALF_18   = 18'(rlec_pkg::PULSE_HALF);
  localparam logic [7:0]  BLINK_8   = 8'(rlec_pkg::BLINK_INTERVAL);

  // Captured input beat
  rlec_pkg::rlec_op_e op_q;
  logic        play_in_q;
  logic [7:0]  mode_in_q;
  logic [7:0]  red_in_q, green_in_q, blue_in_q;
  logic [15:0] dur_in_q;

  // Architectural state
  logic        full_duty_q_en;
  logic [7:0]  full_duty_q;
  logic        play_flag_q;
  logic        custom_on_q;
  rlec_pkg::rlec_mode_e stored_mode_q;
  logic [7:0]  stored_red_q, stored_green_q, stored_blue_q;
  logic [15:0] remaining_q;
  logic        expiry_q;
  logic [7:0]  blink_elapsed_q;
  logic        blink_lit_q;
  logic [9:0]  phase_q;
  logic [7:0]  shown_q [3];
  logic        acc_q;

  // Working registers
  logic [17:0] pq_q;
  logic [7:0]  scale_q;
  logic [15:0] prod_q;
  logic [7:0]  base_q;
  logic [31:0] out_q;

  // Item decode
  logic [10:0] phase_inc;
  logic [9:0]  phase_tick;
  logic [15:0] rem_dec;
  logic        expired;
  logic [7:0]  blink_inc;
  logic        blink_wrap;
  logic        mode_ok;
  logic        show_stat;
  logic        stat_play;

  // Pulse scale
  logic [9:0]  tri_x;
  logic [17:0] tri_n;
  logic [46:0] recip_prod;
  logic [27:0] qh;
  logic [17:0] rem18;
  logic [17:0] q_fix;
  logic [7:0]  pulse_scale;
  logic [7:0]  scale_sel;
  logic [7:0]  level;

  assign full_duty_q_en = cfg_we_i;

  always_comb begin
    phase_inc  = {1'b0, phase_q} + 11'd1;
    phase_tick = (phase_inc >= PERIOD_W) ? 10'd0 : phase_inc[9:0];
    rem_dec    = remaining_q - 16'd1;
    expired    = custom_on_q && expiry_q && (rem_dec == 16'd0);
    blink_inc  = blink_elapsed_q + 8'd1;
    blink_wrap = (blink_inc >= BLINK_8);
    mode_ok    = (mode_in_q <= 8'(rlec_pkg::MODE_PULSE));
    show_stat  = ((op_q == rlec_pkg::OP_TICK) && expired) || (op_q == rlec_pkg::OP_PLAY);
    stat_play  = (op_q == rlec_pkg::OP_PLAY) ? play_in_q : play_flag_q;
    status_o.draw = ((op_q == rlec_pkg::OP_TICK) && custom_on_q && !expired) ||
                    ((op_q == rlec_pkg::OP_EFFECT) && mode_ok);
  end

  always_comb begin
    if (phase_q < HALF_10) begin
      tri_x = phase_q;
    end else if (phase_q <= PERIOD_10) begin
      tri_x = PERIOD_10 - phase_q;
    end else begin
      tri_x = 10'd0;
    end
    tri_n      = ({8'd0, tri_x} << 8) - {8'd0, tri_x};
    recip_prod = {29'd0, tri_n} * {18'd0, rlec_pkg::PULSE_RECIP};
    qh         = {10'd0, pq_q} * 28'(rlec_pkg::PULSE_HALF);
    rem18      = tri_n - qh[17:0];
    q_fix      = (rem18 >= HALF_18) ? pq_q + 18'd1 : pq_q;
    // an odd period lets the falling edge overshoot full scale
    pulse_scale = (q_fix > 18'(rlec_pkg::DUTY_MAX)) ? rlec_pkg::DUTY_MAX : q_fix[7:0];
    unique case (stored_mode_q)
      rlec_pkg::MODE_OFF:   scale_sel = 8'd0;
      rlec_pkg::MODE_SOLID: scale_sel = rlec_pkg::DUTY_MAX;
      rlec_pkg::MODE_BLINK: scale_sel = blink_lit_q ? rlec_pkg::DUTY_MAX : 8'd0;
      rlec_pkg::MODE_PULSE: scale_sel = pulse_scale;
      default:              scale_sel = 8'd0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.ch)
      2'd0:    level = stored_red_q;
      2'd1:    level = stored_green_q;
      default: level = stored_blue_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= rlec_pkg::rlec_op_e'(in_op_i);
      play_in_q  <= in_data_i[0];
      mode_in_q  <= in_data_i[8:1];
      red_in_q   <= in_data_i[16:9];
      green_in_q <= in_data_i[24:17];
      blue_in_q  <= in_data_i[32:25];
      dur_in_q   <= in_data_i[48:33];
    end
    if (cmd_i.scale_mul) pq_q <= recip_prod[rlec_pkg::RECIP_SHIFT +: 18];
    if (cmd_i.scale_fix) scale_q <= scale_sel;
    if (cmd_i.mul1) prod_q <= {8'd0, level} * {8'd0, full_duty_q};
    if (cmd_i.div1) base_q <= rlec_pkg::div255(prod_q);
    if (cmd_i.mul2) prod_q <= {8'd0, base_q} * {8'd0, scale_q};
    if (cmd_i.load_out) begin
      out_q <= {6'd0, custom_on_q, acc_q, shown_q[2], shown_q[1], shown_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_duty_q     <= rlec_pkg::FULL_DUTY_RESET;
      play_flag_q     <= 1'b0;
      custom_on_q     <= 1'b0;
      stored_mode_q   <= rlec_pkg::MODE_OFF;
      stored_red_q    <= 8'd0;
      stored_green_q  <= 8'd0;
      stored_blue_q   <= 8'd0;
      remaining_q     <= 16'd0;
      expiry_q        <= 1'b0;
      blink_elapsed_q <= 8'd0;
      blink_lit_q     <= 1'b1;
      phase_q         <= 10'd0;
      shown_q[0]      <= 8'd0;
      shown_q[1]      <= 8'd0;
      shown_q[2]      <= 8'd0;
      acc_q           <= 1'b1;
    end else begin
      if (full_duty_q_en) full_duty_q <= cfg_wdata_i;
      if (cmd_i.exec) begin
        acc_q <= 1'b1;
        unique case (op_q)
          rlec_pkg::OP_TICK: begin
            phase_q <= phase_tick;
            if (custom_on_q) begin
              if (expiry_q) remaining_q <= rem_dec;
              if (expired) begin
                custom_on_q <= 1'b0;
              end else if (stored_mode_q == rlec_pkg::MODE_BLINK) begin
                blink_elapsed_q <= blink_wrap ? 8'd0 : blink_inc;
                if (blink_wrap) blink_lit_q <= !blink_lit_q;
              end
            end
          end
          rlec_pkg::OP_PLAY: begin
            play_flag_q <= play_in_q;
            custom_on_q <= 1'b0;
          end
          rlec_pkg::OP_EFFECT: begin
            if (!mode_ok) begin
              acc_q <= 1'b0;
            end else begin
              custom_on_q     <= 1'b1;
              stored_mode_q   <= rlec_pkg::rlec_mode_e'(mode_in_q[1:0]);
              stored_red_q    <= red_in_q;
              stored_green_q  <= green_in_q;
              stored_blue_q   <= blue_in_q;
              remaining_q     <= dur_in_q;
              expiry_q        <= (dur_in_q != 16'd0);
              blink_elapsed_q <= 8'd0;
              blink_lit_q     <= 1'b1;
            end
          end
          default: ;
        endcase
        if (show_stat) begin
          shown_q[0] <= stat_play ? 8'd0 : full_duty_q;
          shown_q[1] <= stat_play ? full_duty_q : 8'd0;
          shown_q[2] <= 8'd0;
        end
      end
      if (cmd_i.div2) shown_q[cmd_i.ch] <= rlec_pkg::div255(prod_q);
    end
  end

  assign out_data_o = out_q;

endmodule

// File: src/rlec_checker.sv
`timescale 1ns / 1ps
`include "rgb_led_effect_controller_defines.svh"

module rlec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a result beat holds until taken
  `RLEC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

  // one item in flight: ready drops after each accepted beat
  `RLEC_ASSERT(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second beat taken while busy")

  // without an effect only the red or green status colour can be lit
  `RLEC_ASSERT(a_status_colours, m_axis_tvalid && !m_axis_tdata[25] |-> m_axis_tdata[23:16] == 8'd0 && (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[15:8] == 8'd0), "effect colours shown with no effect running")

endmodule

bind rgb_led_effect_controller rlec_checker u_rlec_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rlec_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SEGMENT_CMDS = 130;

  typedef struct packed {
    rlec_op_e    op;
    logic        play;
    logic [7:0]  mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] duration;
  } led_cmd_t;

  // same layout as m_axis_tdata[25:0]
  typedef struct packed {
    logic       running;
    logic       accepted;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } led_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = OP_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;

  rgb_led_effect_controller DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  led_cmd_t    pending_cmds[$];
  led_result_t expected_duties[$];
  led_cmd_t    cur_cmd;
  int          send_idle_pct = 10;
  int          recv_idle_pct = 85;
  int          hold_req_seq  = 0;
  int          fail_count    = 0;

  // Predictor state
  logic [7:0]  led_full_duty = FULL_DUTY_RESET;
  logic        led_play      = 1'b0;
  logic        led_effect_on = 1'b0;
  rlec_mode_e  led_mode      = MODE_OFF;
  logic [7:0]  led_red       = '0;
  logic [7:0]  led_green     = '0;
  logic [7:0]  led_blue      = '0;
  logic [15:0] led_remaining = '0;
  logic        led_expiry_on = 1'b0;
  logic [7:0]  led_blink_cnt = '0;
  logic        led_blink_lit = 1'b1;
  int unsigned led_phase     = 0;
  logic [7:0]  led_shown[3]  = '{8'd0, 8'd0, 8'd0};

  function automatic logic [7:0] scale_channel(logic [7:0] level, int unsigned scale);
    int unsigned base;
    base = (level * led_full_duty) / 255;
    return 8'((base * scale) / 255);
  endfunction

  function automatic void show_status();
    led_shown[0] = led_play ? 8'd0 : led_full_duty;
    led_shown[1] = led_play ? led_full_duty : 8'd0;
    led_shown[2] = 8'd0;
  endfunction

  function automatic void draw_effect();
    int unsigned scale, half;
    half = PULSE_PERIOD / 2;
    if (half == 0) half = 1;
    case (led_mode)
      MODE_OFF:   scale = 0;
      MODE_SOLID: scale = 255;
      MODE_BLINK: scale = led_blink_lit ? 255 : 0;
      default: begin
        // triangle over the free-running phase
        if (led_phase < half) scale = (led_phase * 255) / half;
        else if (led_phase <= PULSE_PERIOD) scale = ((PULSE_PERIOD - led_phase) * 255) / half;
        else scale = 0;
        if (scale > 255) scale = 255;
      end
    endcase
    led_shown[0] = scale_channel(led_red, scale);
    led_shown[1] = scale_channel(led_green, scale);
    led_shown[2] = scale_channel(led_blue, scale);
  endfunction

  function automatic led_result_t predict_led_step(led_cmd_t c);
    led_result_t r;
    logic expired;
    r.accepted = 1'b1;
    case (c.op)
      OP_TICK: begin
        led_phase = (led_phase + 1 >= PULSE_PERIOD) ? 0 : led_phase + 1;
        if (led_effect_on) begin
          expired = 1'b0;
          if (led_expiry_on) begin
            led_remaining = led_remaining - 16'd1;
            expired = (led_remaining == 16'd0);
          end
          if (expired) begin
            led_effect_on = 1'b0;
            show_status();
          end else begin
            if (led_mode == MODE_BLINK) begin
              led_blink_cnt = led_blink_cnt + 8'd1;
              if (led_blink_cnt >= BLINK_INTERVAL) begin
                led_blink_lit = ~led_blink_lit;
                led_blink_cnt = '0;
              end
            end
            draw_effect();
          end
        end
      end
      OP_PLAY: begin
        led_play      = c.play;
        led_effect_on = 1'b0;
        show_status();
      end
      OP_EFFECT: begin
        if (c.mode > 8'd3) begin
          r.accepted = 1'b0;
        end else begin
          led_effect_on = 1'b1;
          led_mode      = rlec_mode_e'(c.mode[1:0]);
          led_red       = c.red;
          led_green     = c.green;
          led_blue      = c.blue;
          led_remaining = c.duration;
          led_expiry_on = (c.duration != 16'd0);
          led_blink_cnt = '0;
          led_blink_lit = 1'b1;
          draw_effect();
        end
      end
      default: ;
    endcase
    r.red     = led_shown[0];
    r.green   = led_shown[1];
    r.blue    = led_shown[2];
    r.running = led_effect_on;
    return r;
  endfunction

  // Driver: predicts on every accepted beat, then offers the next command.
  always @(posedge clk_i) begin : cmd_driver
    led_cmd_t nxt;
    if (rst_ni) begin
      if (cfg_we_i) led_full_duty = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        expected_duties.push_back(predict_led_step(cur_cmd));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_cmds.pop_front();
          cur_cmd       <= nxt;
          s_axis_tdata  <= {7'd0, nxt.duration, nxt.blue, nxt.green, nxt.red, nxt.mode,
                            nxt.play};
          s_axis_tuser  <= nxt.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results in order and drives tready, with a long hold on request.
  always @(posedge clk_i) begin : result_monitor
    led_result_t got, want;
    static int hold_ack_seq = 0;
    static int hold_left    = 0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[25:0];
        if (expected_duties.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: result beat with nothing expected: r=%0d g=%0d b=%0d acc=%0b run=%0b",
                     got.red, got.green, got.blue, got.accepted, got.running);
        end else begin
          want = expected_duties.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: result mismatch: expected r=%0d g=%0d b=%0d acc=%0b run=%0b",
                       want.red, want.green, want.blue, want.accepted, want.running);
              $display("       got r=%0d g=%0d b=%0d acc=%0b run=%0b",
                       got.red, got.green, got.blue, got.accepted, got.running);
            end
          end
        end
      end
      if (hold_req_seq != hold_ack_seq) begin
        hold_ack_seq = hold_req_seq;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin : quiet_watchdog
    static int quiet = 0;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic void push_cmd(rlec_op_e op, logic play, logic [7:0] mode, logic [7:0] r,
                                   logic [7:0] g, logic [7:0] b, logic [15:0] dur);
    led_cmd_t c;
    c = '{op: op, play: play, mode: mode, red: r, green: g, blue: b, duration: dur};
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One burst of commands; mostly an effect followed by a run of ticks.
  function automatic int queue_random_burst();
    int kind, ticks, n;
    logic [7:0]  mode;
    logic [15:0] dur;
    kind = $urandom_range(99);
    n    = 0;
    if (kind < 10) begin
      push_cmd(rlec_op_e'($urandom_range(3)), 1'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom), 16'($urandom));
      return 1;
    end else if (kind < 20) begin
      push_cmd(OP_PLAY, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 16'($urandom));
      ticks = $urandom_range(5);
    end else if (kind < 28) begin
      push_cmd(OP_EFFECT, 1'($urandom), 8'($urandom_range(255, 4)), random_level(),
               random_level(), random_level(), 16'($urandom));
      ticks = $urandom_range(3);
    end else begin
      mode = 8'($urandom_range(3));
      case ($urandom_range(19))
        0, 1, 2, 3, 4:  dur = 16'd0;
        5, 6, 7:        dur = 16'($urandom);
        8, 9:           dur = 16'($urandom_range(300, 31));
        default:        dur = 16'($urandom_range(30, 1));
      endcase
      push_cmd(OP_EFFECT, 1'($urandom), mode, random_level(), random_level(), random_level(),
               dur);
      // long runs let the blink toggle and the pulse move along its triangle
      if (mode >= 8'd2 && $urandom_range(3) == 0) ticks = $urandom_range(320, 250);
      else ticks = $urandom_range(40);
    end
    n = 1;
    repeat (ticks) begin
      push_cmd(OP_TICK, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 16'($urandom));
      n++;
    end
    return n;
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_duties.size() != 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_full_duty(logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0] duty_plan[6];
    int queued;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_full_duty(8'd255);

    // directed: idle display, each operation, expiry, rejected modes, field extremes
    push_cmd(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_NONE,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_PLAY,   1'b1, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_PLAY,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_EFFECT, 1'b0, 8'(MODE_SOLID), 8'd255, 8'd255, 8'd255, 16'd0);
    push_cmd(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_EFFECT, 1'b0, 8'(MODE_BLINK), 8'd255, 8'd0,   8'd128, 16'hFFFF);
    push_cmd(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_EFFECT, 1'b0, 8'(MODE_PULSE), 8'd0,   8'd255, 8'd255, 16'd2);
    push_cmd(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_EFFECT, 1'b0, 8'(MODE_OFF),   8'd200, 8'd100, 8'd50,  16'd0);
    push_cmd(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_EFFECT, 1'b1, 8'd4,   8'd255, 8'd255, 8'd255, 16'hFFFF);
    push_cmd(OP_EFFECT, 1'b0, 8'd255, 8'd1,   8'd2,   8'd3,   16'd5);
    push_cmd(OP_EFFECT, 1'b0, 8'(MODE_SOLID), 8'd1,   8'd2,   8'd3,   16'd1);
    push_cmd(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_PLAY,   1'b1, 8'hFF,  8'hFF,  8'hFF,  8'hFF,  16'hFFFF);
    push_cmd(OP_NONE,   1'b1, 8'hFF,  8'hFF,  8'hFF,  8'hFF,  16'hFFFF);
    push_cmd(OP_EFFECT, 1'b0, 8'(MODE_SOLID), 8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_PLAY,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    push_cmd(OP_TICK,   1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'd0);
    wait_drained();

    duty_plan = '{8'd0, 8'($urandom_range(254, 2)), 8'd1, 8'($urandom_range(254, 2)), 8'd255,
                  8'($urandom_range(254, 2))};
    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 10 : (seg < 4) ? 85 : 0;
      recv_idle_pct = (seg < 2) ? 85 : (seg < 4) ? 10 : 0;
      write_full_duty(duty_plan[seg]);
      queued = 0;
      while (queued < SEGMENT_CMDS / 2) queued += queue_random_burst();
      if (seg == 4) begin
        // sink holds off while the source keeps offering
        while (pending_cmds.size() > queued / 2) @(negedge clk_i);
        hold_req_seq++;
      end
      // source pauses until every result is in
      wait_drained();
      while (queued < SEGMENT_CMDS) queued += queue_random_burst();
      wait_drained();
    end

    fail_count += expected_duties.size();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
